### src/sbsh_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

package sbsh_pkg;

    localparam int WORD_W     = 32;
    localparam int BLOCK_BITS = 512;
    localparam int NUM_ROUNDS = 64;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [2:0] LEN_START  = 3'd7;   // fill position 56 and above, bits [5:3]
    localparam logic [2:0] LAST_INDEX = 3'd7;

    // Eight 32-bit words; element [0] is word 0 (a for the working set).
    typedef logic [7:0][WORD_W-1:0] chain_t;

    localparam chain_t IV_WORDS = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [WORD_W-1:0] ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    // Sequencer commands to the datapath core.
    typedef struct packed {
        logic       shift_byte;   // push one byte into the block buffer
        logic [7:0] byte_val;
        logic       init_work;    // load working words from the chain
        logic       round;        // run one compression round
        logic [5:0] round_idx;
        logic       fold;         // add working words into the chain
        logic       reset_chain;  // return chain to the initial values
    } core_ctrl_t;

endpackage

### src/sbsh_core.sv
// SHA-256 datapath: block buffer / schedule window, shared round unit, chain words.
`timescale 1ns / 1ps

module sbsh_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  sbsh_pkg::core_ctrl_t ctrl,
    output sbsh_pkg::chain_t    chain_words
);

    logic [sbsh_pkg::BLOCK_BITS-1:0] buf_reg;
    sbsh_pkg::chain_t                work_reg;
    sbsh_pkg::chain_t                work_next;
    sbsh_pkg::chain_t                chain_reg;
    logic [31:0]                     w_new;
    logic [31:0]                     t1;
    logic [31:0]                     t2;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    // Word k of the 16-word window, word 0 in the top bits.
    function automatic logic [31:0] win(input logic [sbsh_pkg::BLOCK_BITS-1:0] b,
                                        input int k);
        win = b[sbsh_pkg::BLOCK_BITS-1-32*k -: 32];
    endfunction

    // Schedule expansion and round function
    always_comb begin
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] a;
        logic [31:0] e;
        logic [31:0] ch;
        logic [31:0] maj;
        x = win(buf_reg, 1);
        y = win(buf_reg, 14);
        w_new = win(buf_reg, 0) + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3))
              + win(buf_reg, 9) + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
        a   = work_reg[0];
        e   = work_reg[4];
        ch  = (e & work_reg[5]) ^ (~e & work_reg[6]);
        maj = (a & work_reg[1]) ^ (a & work_reg[2]) ^ (work_reg[1] & work_reg[2]);
        t1  = work_reg[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ch
            + sbsh_pkg::ROUND_K[ctrl.round_idx] + win(buf_reg, 0);
        t2  = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + maj;
        work_next    = work_reg;
        work_next[7] = work_reg[6];
        work_next[6] = work_reg[5];
        work_next[5] = work_reg[4];
        work_next[4] = work_reg[3] + t1;
        work_next[3] = work_reg[2];
        work_next[2] = work_reg[1];
        work_next[1] = work_reg[0];
        work_next[0] = t1 + t2;
    end

    // Shift bytes in while filling, shift schedule words while compressing
    always_ff @(posedge aclk) begin
        if (ctrl.shift_byte) begin
            buf_reg <= {buf_reg[sbsh_pkg::BLOCK_BITS-9:0], ctrl.byte_val};
        end else if (ctrl.round) begin
            buf_reg <= {buf_reg[sbsh_pkg::BLOCK_BITS-33:0], w_new};
        end
    end

    // Working words
    always_ff @(posedge aclk) begin
        if (ctrl.init_work) begin
            work_reg <= chain_reg;
        end else if (ctrl.round) begin
            work_reg <= work_next;
        end
    end

    // Chain words: fold after each block, restart after the digest leaves
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.reset_chain) begin
            chain_reg <= sbsh_pkg::IV_WORDS;
        end else if (ctrl.fold) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
    end

    assign chain_words = chain_reg;

endmodule

### src/sha256_byte_stream_hasher.sv
// Top level: SHA-256 byte stream hasher with byte fill, padding and round sequencer.
// Each byte is absorbed in ST_IDLE; the byte that completes a block starts 64 rounds and a fold.
// Finish pads one byte per cycle to the block end, then 64 rounds and a fold;
// a second final block adds a full block of pad bytes and another compression.
// The digest leaves as 8 transactions, one per cycle when m_ready is high; s_ready is low meanwhile.
// s_ready stays low while the single shared round unit compresses a block.
// Synchronous active-low reset restores the initial chain words and a zero bit count.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sbsh_pkg::state_t     state_reg;
    sbsh_pkg::state_t     state_next;
    logic [5:0]           fill_reg;
    logic [5:0]           fill_next;
    logic [60:0]          count_reg;    // byte count; bit count is this times 8
    logic [60:0]          count_next;
    logic [5:0]           round_reg;
    logic [5:0]           round_next;
    logic [2:0]           idx_reg;
    logic [2:0]           idx_next;
    logic                 finishing_reg;
    logic                 finishing_next;
    logic                 two_blk_reg;
    logic                 two_blk_next;
    sbsh_pkg::core_ctrl_t ctrl;
    sbsh_pkg::chain_t     chain_words;
    logic [63:0]          len_shift;
    logic [7:0]           pad_byte;

    sbsh_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .chain_words (chain_words)
    );

    // Pad byte: big-endian length in the last eight slots of the final block, else zero
    always_comb begin
        len_shift = {count_reg, 3'b000} >> {~fill_reg[2:0], 3'b000};
        if (fill_reg[5:3] == sbsh_pkg::LEN_START && !two_blk_reg) begin
            pad_byte = len_shift[7:0];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sbsh_pkg::ST_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            finishing_reg <= 1'b0;
            two_blk_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            finishing_reg <= finishing_next;
            two_blk_reg   <= two_blk_next;
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        finishing_next = finishing_reg;
        two_blk_next   = two_blk_reg;
        ctrl           = '0;
        ctrl.round_idx = round_reg;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        unique case (state_reg)
            sbsh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.shift_byte = 1'b1;
                    fill_next       = fill_reg + 6'd1;
                    if (s_func) begin
                        ctrl.byte_val  = sbsh_pkg::PAD_MARK;
                        finishing_next = 1'b1;
                        two_blk_next   = (fill_reg[5:3] == sbsh_pkg::LEN_START);
                    end else begin
                        ctrl.byte_val = s_data_byte;
                        count_next    = count_reg + 61'd1;
                    end
                    if (fill_reg == sbsh_pkg::LAST_BYTE) begin
                        ctrl.init_work = 1'b1;
                        round_next     = '0;
                        state_next     = sbsh_pkg::ST_ROUND;
                    end else if (s_func) begin
                        state_next = sbsh_pkg::ST_PAD;
                    end
                end
            end
            sbsh_pkg::ST_PAD: begin
                ctrl.shift_byte = 1'b1;
                ctrl.byte_val   = pad_byte;
                fill_next       = fill_reg + 6'd1;
                if (fill_reg == sbsh_pkg::LAST_BYTE) begin
                    ctrl.init_work = 1'b1;
                    round_next     = '0;
                    state_next     = sbsh_pkg::ST_ROUND;
                end
            end
            sbsh_pkg::ST_ROUND: begin
                ctrl.round = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == sbsh_pkg::LAST_ROUND) begin
                    state_next = sbsh_pkg::ST_FOLD;
                end
            end
            sbsh_pkg::ST_FOLD: begin
                ctrl.fold = 1'b1;
                if (!finishing_reg) begin
                    state_next = sbsh_pkg::ST_IDLE;
                end else if (two_blk_reg) begin
                    two_blk_next = 1'b0;
                    state_next   = sbsh_pkg::ST_PAD;
                end else begin
                    idx_next   = '0;
                    state_next = sbsh_pkg::ST_OUT;
                end
            end
            sbsh_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sbsh_pkg::LAST_INDEX) begin
                        ctrl.reset_chain = 1'b1;
                        count_next       = '0;
                        finishing_next   = 1'b0;
                        state_next       = sbsh_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sbsh_pkg::ST_IDLE;
            end
        endcase
    end

    // Digest word straight from the chain registers
    assign m_digest_word = chain_words[idx_reg];
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == sbsh_pkg::LAST_INDEX);

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while digest is pending");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_word |=> s_ready && fill_reg == 6'd0)
        else $error("hasher not idle after last digest word");

    a_round_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && fill_reg == sbsh_pkg::LAST_BYTE
        |=> state_reg == sbsh_pkg::ST_ROUND && round_reg == 6'd0)
        else $error("full block did not start compression at round zero");

    a_fold_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sbsh_pkg::ST_FOLD |-> $past(round_reg) == sbsh_pkg::LAST_ROUND)
        else $error("fold reached before the last round");
`endif

endmodule
